### rtl/core/ipv4sd_pkg.sv
// ----------------------------------------------------------------------------
// ipv4sd_pkg
// Shared types and constants for the descending IPv4 sort and filter unit.
// ----------------------------------------------------------------------------
package ipv4sd_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [1:0] CFG_MATCH_FIRST  = 2'd1;
  localparam logic [1:0] CFG_MATCH_SECOND = 2'd2;

  // filter mode codes
  localparam logic [1:0] FILTER_NONE      = 2'd0;
  localparam logic [1:0] FILTER_FIRST     = 2'd1;
  localparam logic [1:0] FILTER_FIRST_TWO = 2'd2;
  localparam logic [1:0] FILTER_ANY       = 2'd3;

  // input transaction
  typedef struct packed {
    logic [7:0] octet_a;
    logic [7:0] octet_b;
    logic [7:0] octet_c;
    logic [7:0] octet_d;
    logic       end_of_set;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [7:0] out_c;
    logic [7:0] out_d;
    logic       final_item;
    logic       none_matched;
    logic       dropped_some;
  } out_item_t;

  // filter configuration
  typedef struct packed {
    logic [1:0] filter_mode;
    logic [7:0] match_first;
    logic [7:0] match_second;
  } filter_cfg_t;

endpackage

### rtl/core/ipv4sd_store.sv
// ----------------------------------------------------------------------------
// ipv4sd_store
// Address store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ipv4sd_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/core/ipv4sd_scan.sv
// ----------------------------------------------------------------------------
// ipv4sd_scan
// Scan unit: tracks the largest untaken address that passes the filter and
// counts how many untaken addresses pass, over one pass through the store.
// ----------------------------------------------------------------------------
module ipv4sd_scan #(
  parameter int unsigned IW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic                     vld_i,
  input  logic [IW-1:0]            idx_i,
  input  logic                     taken_i,
  input  logic [31:0]              data_i,
  input  ipv4sd_pkg::filter_cfg_t  cfg_i,
  output logic                     found_o,
  output logic [31:0]              best_addr_o,
  output logic [IW-1:0]            best_idx_o,
  output logic [CW-1:0]            remaining_o
);

  logic          found_q;
  logic [31:0]   best_addr_q;
  logic [IW-1:0] best_idx_q;
  logic [CW-1:0] remaining_q;
  logic          pass;
  logic          hit;
  logic          better;

  // filter decision on the read data
  always_comb begin
    case (cfg_i.filter_mode)
      ipv4sd_pkg::FILTER_FIRST:
        pass = (data_i[31:24] == cfg_i.match_first);
      ipv4sd_pkg::FILTER_FIRST_TWO:
        pass = (data_i[31:24] == cfg_i.match_first) &&
               (data_i[23:16] == cfg_i.match_second);
      ipv4sd_pkg::FILTER_ANY:
        pass = (data_i[31:24] == cfg_i.match_first) ||
               (data_i[23:16] == cfg_i.match_first) ||
               (data_i[15:8]  == cfg_i.match_first) ||
               (data_i[7:0]   == cfg_i.match_first);
      default:
        pass = 1'b1;
    endcase
  end

  assign hit    = vld_i & ~taken_i & pass;
  assign better = hit & (~found_q | (data_i > best_addr_q));

  // running maximum and pass count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      remaining_q <= '0;
    end else if (clr_i) begin
      found_q     <= 1'b0;
      remaining_q <= '0;
    end else if (hit) begin
      found_q     <= 1'b1;
      remaining_q <= remaining_q + CW'(1);
    end
  end

  // best candidate payload
  always_ff @(posedge clk_i) begin
    if (better) begin
      best_addr_q <= data_i;
      best_idx_q  <= idx_i;
    end
  end

  assign found_o     = found_q;
  assign best_addr_o = best_addr_q;
  assign best_idx_o  = best_idx_q;
  assign remaining_o = remaining_q;

endmodule

### rtl/core/ipv4_sort_descending_filter_unit.sv
// ----------------------------------------------------------------------------
// ipv4_sort_descending_filter_unit
// Loads IPv4 addresses into a store, then emits them in descending order,
// filtered by the configured prefix or byte match.
// ----------------------------------------------------------------------------
// Loading takes input back to back while the unit is idle.
// After the last address, each result takes a scan that reads every stored
// entry once, then pipeline drain, decision and output, plus any output stall;
// input is held off until the last result of the set has been taken.
// Reset clears the fill count, the overflow flag, the configuration and the
// control; the store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module ipv4_sort_descending_filter_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ipv4sd_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ipv4sd_pkg::out_item_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;
  logic [IW-1:0]           scan_idx_q, scan_idx_d;
  logic                    rd_vld_q;
  logic [IW-1:0]           rd_idx_q;
  logic [CAPACITY-1:0]     taken_q, taken_d;
  logic                    decide_q, decide_d;
  ipv4sd_pkg::out_item_t   out_item_q, out_item_d;
  ipv4sd_pkg::filter_cfg_t cfg_q;

  logic          in_acc;
  logic          store_we;
  logic          rd_en;
  logic [31:0]   rdata;
  logic          scan_clr;
  logic          found;
  logic [31:0]   best_addr;
  logic [IW-1:0] best_idx;
  logic [CW-1:0] remaining;
  logic          last_issue;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign store_we    = in_acc & (cnt_q < CW'(CAPACITY));
  assign rd_en       = (state_q == ST_SCAN);
  assign last_issue  = ((CW'(scan_idx_q) + CW'(1)) == cnt_q);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == ST_EMIT) & ~decide_q;
  assign out_item_o  = out_item_q;

  // address store
  ipv4sd_store #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({in_item_i.octet_a, in_item_i.octet_b,
               in_item_i.octet_c, in_item_i.octet_d}),
    .re_i    (rd_en),
    .raddr_i (scan_idx_q),
    .rdata_o (rdata)
  );

  // maximum search over one pass
  ipv4sd_scan #(
    .IW       (IW),
    .CW       (CW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (scan_clr),
    .vld_i       (rd_vld_q),
    .idx_i       (rd_idx_q),
    .taken_i     (taken_q[rd_idx_q]),
    .data_i      (rdata),
    .cfg_i       (cfg_q),
    .found_o     (found),
    .best_addr_o (best_addr),
    .best_idx_o  (best_idx),
    .remaining_o (remaining)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ipv4sd_pkg::CFG_FILTER_MODE:  cfg_q.filter_mode  <= cfg_data_i[1:0];
        ipv4sd_pkg::CFG_MATCH_FIRST:  cfg_q.match_first  <= cfg_data_i;
        ipv4sd_pkg::CFG_MATCH_SECOND: cfg_q.match_second <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // read pipeline tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      rd_vld_q <= rd_en;
      rd_idx_q <= scan_idx_q;
    end
  end

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    scan_idx_d = scan_idx_q;
    taken_d    = taken_q;
    decide_d   = decide_q;
    out_item_d = out_item_q;
    scan_clr   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (store_we) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_item_i.end_of_set) begin
            state_d    = ST_SCAN;
            scan_idx_d = '0;
            taken_d    = '0;
            scan_clr   = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        scan_idx_d = scan_idx_q + IW'(1);
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data is folded in at this edge
        state_d  = ST_EMIT;
        decide_d = 1'b1;
      end
      ST_EMIT: begin
        if (decide_q) begin
          decide_d = 1'b0;
          out_item_d.dropped_some = ovf_q;
          if (found) begin
            out_item_d.out_a        = best_addr[31:24];
            out_item_d.out_b        = best_addr[23:16];
            out_item_d.out_c        = best_addr[15:8];
            out_item_d.out_d        = best_addr[7:0];
            out_item_d.none_matched = 1'b0;
            out_item_d.final_item   = (remaining == CW'(1));
            taken_d[best_idx]       = 1'b1;
          end else begin
            out_item_d.out_a        = '0;
            out_item_d.out_b        = '0;
            out_item_d.out_c        = '0;
            out_item_d.out_d        = '0;
            out_item_d.none_matched = 1'b1;
            out_item_d.final_item   = 1'b1;
          end
        end else if (out_ready_i) begin
          if (out_item_q.final_item) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
            ovf_d   = 1'b0;
          end else begin
            state_d    = ST_SCAN;
            scan_idx_d = '0;
            scan_clr   = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      scan_idx_q <= '0;
      taken_q    <= '0;
      decide_q   <= 1'b0;
      out_item_q <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      scan_idx_q <= scan_idx_d;
      taken_q    <= taken_d;
      decide_q   <= decide_d;
      out_item_q <= out_item_d;
    end
  end

endmodule

### tb/ipv4_sort_descending_filter_unit_tb.sv
// ----------------------------------------------------------------------------
// ipv4_sort_descending_filter_unit_tb
// Loads sets of IPv4 addresses through the input channel under a range of
// filter settings and checks every emitted address, empty-set marker, last
// flag and overflow flag against an in-bench prediction of the sorted and
// filtered output. Both channels stall at random.
// ----------------------------------------------------------------------------
module ipv4_sort_descending_filter_unit_tb;

  localparam int unsigned STORE_DEPTH   = 64;
  localparam int unsigned ITEMS_TARGET  = 370;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 24;

  // register index outside the register list, writes are ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] idx;
    logic [7:0] data;
  } reg_write_t;

  // prediction of the sorted, filtered output and comparison with the block
  class addr_order_board;
    logic [31:0]             held_addrs[$];
    bit                      overflowed;
    ipv4sd_pkg::filter_cfg_t cfg;
    ipv4sd_pkg::out_item_t   expected_emits[$];
    int unsigned             errors;

    function new();
      overflowed = 1'b0;
      cfg        = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        ipv4sd_pkg::CFG_FILTER_MODE:  cfg.filter_mode  = data[1:0];
        ipv4sd_pkg::CFG_MATCH_FIRST:  cfg.match_first  = data;
        ipv4sd_pkg::CFG_MATCH_SECOND: cfg.match_second = data;
        default: ;
      endcase
    endfunction

    function bit passes(logic [31:0] addr);
      logic [7:0] a, b, c, d;
      {a, b, c, d} = addr;
      case (cfg.filter_mode)
        ipv4sd_pkg::FILTER_FIRST:
          return a == cfg.match_first;
        ipv4sd_pkg::FILTER_FIRST_TWO:
          return a == cfg.match_first && b == cfg.match_second;
        ipv4sd_pkg::FILTER_ANY:
          return a == cfg.match_first || b == cfg.match_first ||
                 c == cfg.match_first || d == cfg.match_first;
        default:
          return 1'b1;
      endcase
    endfunction

    // note an accepted address, on the end of a set queue up its emits
    function void load_address(ipv4sd_pkg::in_item_t it);
      logic [31:0]           addr;
      ipv4sd_pkg::out_item_t emit;
      int unsigned           first;
      addr = {it.octet_a, it.octet_b, it.octet_c, it.octet_d};
      if (held_addrs.size() < STORE_DEPTH) held_addrs.insert(held_addrs.size(), addr);
      else overflowed = 1'b1;
      if (!it.end_of_set) return;
      first = expected_emits.size();
      held_addrs.rsort();
      foreach (held_addrs[i]) begin
        if (passes(held_addrs[i])) begin
          emit = '0;
          {emit.out_a, emit.out_b, emit.out_c, emit.out_d} = held_addrs[i];
          emit.dropped_some = overflowed;
          expected_emits.insert(expected_emits.size(), emit);
        end
      end
      if (expected_emits.size() == first) begin
        emit = '0;
        emit.none_matched = 1'b1;
        emit.dropped_some = overflowed;
        expected_emits.insert(expected_emits.size(), emit);
      end
      expected_emits[expected_emits.size() - 1].final_item = 1'b1;
      held_addrs.delete();
      overflowed = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_emits.size();
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // compare one emitted transaction with the oldest expectation
    task check_emitted(ipv4sd_pkg::out_item_t got);
      ipv4sd_pkg::out_item_t want;
      if (expected_emits.size() == 0) begin
        report($sformatf("unexpected result %0d.%0d.%0d.%0d",
                         got.out_a, got.out_b, got.out_c, got.out_d));
        return;
      end
      want = expected_emits.pop_front();
      check_field("out_a", got.out_a, want.out_a);
      check_field("out_b", got.out_b, want.out_b);
      check_field("out_c", got.out_c, want.out_c);
      check_field("out_d", got.out_d, want.out_d);
      check_field("final_item", got.final_item, want.final_item);
      check_field("none_matched", got.none_matched, want.none_matched);
      check_field("dropped_some", got.dropped_some, want.dropped_some);
    endtask
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  ipv4sd_pkg::in_item_t  in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  ipv4sd_pkg::out_item_t out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i = ipv4sd_pkg::CFG_FILTER_MODE;
  logic [7:0]            cfg_data_i  = '0;

  addr_order_board board = new();
  reg_write_t      pending_writes[$];
  int unsigned     items_sent = 0;
  bit              steady     = 1'b0;

  // append one register write to the pending list
  function automatic void queue_write(input logic [1:0] idx, input logic [7:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    pending_writes.insert(pending_writes.size(), w);
  endfunction

  ipv4_sort_descending_filter_unit #(
    .CAPACITY(STORE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // result side: check each transaction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_emitted(out_item_o);
      out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // one address transaction, then random idle cycles
  task automatic send_addr(input ipv4sd_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.load_address(it);
    items_sent++;
    steady <= (items_sent >= 150 && items_sent < 240);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_fixed(input logic [31:0] addr, input bit last);
    ipv4sd_pkg::in_item_t it;
    {it.octet_a, it.octet_b, it.octet_c, it.octet_d} = addr;
    it.end_of_set = last;
    send_addr(it);
  endtask

  // bias towards the match byte and the byte extremes
  function automatic logic [7:0] pick_octet(input logic [7:0] pref);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return pref;
    if (r < 42) return 8'h00;
    if (r < 49) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // one set of random addresses, some repeated, the last one marked
  task automatic send_set(input int unsigned n);
    ipv4sd_pkg::in_item_t it;
    logic [7:0]           mf, ms;
    int unsigned          k;
    it = '0;
    mf = board.cfg.match_first;
    ms = board.cfg.match_second;
    for (k = 0; k < n; k++) begin
      if (k == 0 || $urandom_range(0, 9) != 0) begin
        it.octet_a = pick_octet(mf);
        it.octet_b = pick_octet($urandom_range(0, 1) ? ms : mf);
        it.octet_c = pick_octet(mf);
        it.octet_d = pick_octet(mf);
      end
      it.end_of_set = (k == n - 1);
      send_addr(it);
    end
  endtask

  // register writes back to back from the pending list
  task automatic apply_reg_writes();
    reg_write_t w;
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      do @(posedge clk_i); while (!cfg_ready_o);
      board.write_reg(w.idx, w.data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // stop loading and let every expected result drain out
  task automatic wait_idle(input int unsigned extra);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    logic [1:0]  modes[4];
    logic [1:0]  reg_order[3];
    int unsigned big_sizes[3];
    int unsigned phase, set_no, big_done, start, size;
    logic [7:0]  mf, ms;
    modes     = '{ipv4sd_pkg::FILTER_NONE, ipv4sd_pkg::FILTER_FIRST,
                  ipv4sd_pkg::FILTER_FIRST_TWO, ipv4sd_pkg::FILTER_ANY};
    reg_order = '{ipv4sd_pkg::CFG_FILTER_MODE, ipv4sd_pkg::CFG_MATCH_FIRST,
                  ipv4sd_pkg::CFG_MATCH_SECOND};
    big_sizes = '{64, 65, 71};
    phase     = 0;
    set_no    = 0;
    big_done  = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings pass everything: single set, then extremes and duplicates
    send_fixed(32'hFFFF_FFFF, 1'b1);
    send_fixed(32'h0000_0000, 1'b0);
    send_fixed(32'h8001_0203, 1'b0);
    send_fixed(32'hFF00_0000, 1'b0);
    send_fixed(32'h00FF_FFFF, 1'b0);
    send_fixed(32'h8001_0203, 1'b0);
    send_fixed(32'h0102_0304, 1'b1);
    wait_idle(SETTLE_CYCLES);

    // first byte filter, mode written with spare high bits, unused index
    queue_write(ipv4sd_pkg::CFG_FILTER_MODE, {6'h3F, ipv4sd_pkg::FILTER_FIRST});
    queue_write(ipv4sd_pkg::CFG_MATCH_FIRST, 8'd128);
    queue_write(CFG_UNUSED, 8'hFF);
    apply_reg_writes();
    send_fixed(32'h8000_0000, 1'b0);
    send_fixed(32'h7FFF_FFFF, 1'b0);
    send_fixed(32'h80FF_0001, 1'b1);
    wait_idle(SETTLE_CYCLES);

    // first two bytes filter
    queue_write(ipv4sd_pkg::CFG_FILTER_MODE, {6'h00, ipv4sd_pkg::FILTER_FIRST_TWO});
    queue_write(ipv4sd_pkg::CFG_MATCH_FIRST, 8'd10);
    queue_write(ipv4sd_pkg::CFG_MATCH_SECOND, 8'd20);
    apply_reg_writes();
    send_fixed(32'h0A14_0101, 1'b0);
    send_fixed(32'h0A15_0000, 1'b0);
    send_fixed(32'h0A14_FFFF, 1'b1);
    wait_idle(SETTLE_CYCLES);

    // any byte filter, then a set where nothing passes
    queue_write(ipv4sd_pkg::CFG_FILTER_MODE, {6'h00, ipv4sd_pkg::FILTER_ANY});
    queue_write(ipv4sd_pkg::CFG_MATCH_FIRST, 8'd0);
    apply_reg_writes();
    send_fixed(32'h0102_0300, 1'b0);
    send_fixed(32'h0101_0101, 1'b1);
    send_fixed(32'h0101_0101, 1'b1);

    // random phases: new settings, then a few sets, some past capacity
    while (items_sent < ITEMS_TARGET) begin
      wait_idle(SETTLE_CYCLES);
      mf = (phase == 1) ? 8'h00 : (phase == 2) ? 8'hFF : 8'($urandom_range(0, 255));
      ms = (phase == 3) ? 8'hFF : (phase == 6) ? 8'h00 : 8'($urandom_range(0, 255));
      start = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        case (reg_order[(start + k) % 3])
          ipv4sd_pkg::CFG_FILTER_MODE: queue_write(ipv4sd_pkg::CFG_FILTER_MODE,
            {6'($urandom_range(0, 63)), modes[phase % 4]});
          ipv4sd_pkg::CFG_MATCH_FIRST: queue_write(ipv4sd_pkg::CFG_MATCH_FIRST, mf);
          default:                     queue_write(ipv4sd_pkg::CFG_MATCH_SECOND, ms);
        endcase
      end
      if ($urandom_range(0, 3) == 0)
        queue_write(CFG_UNUSED, 8'($urandom_range(0, 255)));
      apply_reg_writes();
      repeat ($urandom_range(1, 4)) begin
        if (set_no % 8 == 3 && big_done < 3) begin
          size = big_sizes[big_done];
          big_done++;
        end else begin
          size = $urandom_range(1, 10);
        end
        send_set(size);
        set_no++;
      end
      phase++;
    end

    wait_idle(20);
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### ipv4_sort_descending_filter_unit.f
rtl/core/ipv4sd_pkg.sv
rtl/core/ipv4sd_store.sv
rtl/core/ipv4sd_scan.sv
rtl/core/ipv4_sort_descending_filter_unit.sv
tb/ipv4_sort_descending_filter_unit_tb.sv
